FILE: rtl/pra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pra_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam int ANGLE_WIDTH = 16;
    localparam int TURN_WIDTH  = 15;   // reduced angle, 0 .. 23039
    localparam int REM_WIDTH   = 13;   // angle within a quadrant, 0 .. 5759
    localparam int OCT_WIDTH   = 12;   // octant angle, 0 .. 2880

    localparam int RAD_WIDTH   = 30;   // octant angle in radians, Q30
    localparam int TRIG_WIDTH  = 31;   // sin/cos magnitude, Q30, up to 1.0
    localparam int PROD_WIDTH  = COORD_WIDTH + 32;
    localparam int SUM_WIDTH   = COORD_WIDTH + 33;
    localparam int RND_WIDTH   = SUM_WIDTH - 30;

    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int THREE_QUARTERS = 17280;
    localparam int QUARTER_TURN = 5760;
    localparam int EIGHTH_TURN  = 2880;
    localparam int TWO_TURNS    = 46080;

    // rad = t*RAD_Q + floor((t*RAD_R + 5760) / 11520), pi*2^30 = 11520*RAD_Q + RAD_R
    localparam int RAD_Q        = 292817;
    localparam int RAD_R        = 7586;
    localparam int RAD_BIAS     = 5760;
    localparam int DIV45_RECIP  = 186414;   // ceil(2^23 / 45)

    localparam int HORNER_STEPS = 6;
    localparam int unsigned SIN_DIV [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [HORNER_STEPS] = '{132, 90, 56, 30, 12, 2};

    localparam logic [TRIG_WIDTH-1:0] ONE_Q30 = TRIG_WIDTH'(1) << 30;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
        logic signed [ANGLE_WIDTH-1:0] angle;
    } pra_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        logic                          saturated;
    } pra_out_t;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        quad_t                         quad;
        logic                          swap;
        logic [OCT_WIDTH-1:0]          oct;
    } pra_item_t;

endpackage
`default_nettype wire

FILE: rtl/pra_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module pra_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  pra_pkg::pra_item_t  wr_item,
    output logic                rd_valid,
    input  logic                rd_pop,
    output pra_pkg::pra_item_t  rd_item
);
    import pra_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pra_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pra_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pra_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pra_pkg::pra_in_t    s_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pra_pkg::pra_item_t  out_item
);
    import pra_pkg::*;

    logic                  valid_reg, valid_next;
    pra_item_t             item_reg, item_next;
    logic signed [17:0]    shifted;
    logic [16:0]           v;
    logic [TURN_WIDTH-1:0] u;
    logic [REM_WIDTH-1:0]  r;
    quad_t                 quad;
    logic                  swap;

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // reduce angle to [0, full turn), then to quadrant and octant
    always_comb begin
        shifted = 18'(s_data.angle) + 18'sd46080;
        v       = shifted[16:0];
        priority if (v >= 17'(TWO_TURNS + FULL_TURN)) begin
            u = TURN_WIDTH'(v - 17'(TWO_TURNS + FULL_TURN));
        end else if (v >= 17'(TWO_TURNS)) begin
            u = TURN_WIDTH'(v - 17'(TWO_TURNS));
        end else if (v >= 17'(FULL_TURN)) begin
            u = TURN_WIDTH'(v - 17'(FULL_TURN));
        end else begin
            u = TURN_WIDTH'(v);
        end

        priority if (u >= TURN_WIDTH'(THREE_QUARTERS)) begin
            quad = QUAD_3;
            r    = REM_WIDTH'(u - TURN_WIDTH'(THREE_QUARTERS));
        end else if (u >= TURN_WIDTH'(HALF_TURN)) begin
            quad = QUAD_2;
            r    = REM_WIDTH'(u - TURN_WIDTH'(HALF_TURN));
        end else if (u >= TURN_WIDTH'(QUARTER_TURN)) begin
            quad = QUAD_1;
            r    = REM_WIDTH'(u - TURN_WIDTH'(QUARTER_TURN));
        end else begin
            quad = QUAD_0;
            r    = REM_WIDTH'(u);
        end

        swap           = (r > REM_WIDTH'(EIGHTH_TURN));
        item_next.x    = s_data.x_in;
        item_next.y    = s_data.y_in;
        item_next.quad = quad;
        item_next.swap = swap;
        item_next.oct  = swap ? OCT_WIDTH'(REM_WIDTH'(QUARTER_TURN) - r) : OCT_WIDTH'(r);
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pra_step.sv
`timescale 1ns / 1ps
`default_nettype none
// One Horner step: k_o = 2^30 - floor(floor(x2*k / 2^30) / DIV), registered through p_reg, q0_reg and k_reg.
module pra_step #(
    parameter int unsigned DIV = 2
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [pra_pkg::RAD_WIDTH-1:0]     x2_i,
    input  logic [pra_pkg::TRIG_WIDTH-1:0]    k_i,
    output logic [pra_pkg::RAD_WIDTH-1:0]     x2_o,
    output logic [pra_pkg::TRIG_WIDTH-1:0]    k_o
);
    import pra_pkg::*;

    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

    logic [60:0]           prod;
    logic [61:0]           est;
    logic [RAD_WIDTH-1:0]  qd;
    logic [RAD_WIDTH-1:0]  rem;
    logic [RAD_WIDTH-1:0]  quo;

    logic [RAD_WIDTH-1:0]  p_reg, p2_reg, q0_reg;
    logic [RAD_WIDTH-1:0]  x2a_reg, x2b_reg, x2c_reg;
    logic [TRIG_WIDTH-1:0] k_reg;

    assign prod = 61'(x2_i) * 61'(k_i);
    assign est  = 62'(p_reg) * 62'(RECIP);
    // estimate is low by at most one
    assign qd   = RAD_WIDTH'(40'(q0_reg) * 40'(DIV));
    assign rem  = p2_reg - qd;
    assign quo  = q0_reg + RAD_WIDTH'(rem >= RAD_WIDTH'(DIV));

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg   <= prod[59:30];
            x2a_reg <= x2_i;
            q0_reg  <= est[61:32];
            p2_reg  <= p_reg;
            x2b_reg <= x2a_reg;
            k_reg   <= ONE_Q30 - TRIG_WIDTH'(quo);
            x2c_reg <= x2b_reg;
        end
    end

    assign x2_o = x2c_reg;
    assign k_o  = k_reg;

endmodule
`default_nettype wire

FILE: rtl/pra_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pra_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_pop,
    input  pra_pkg::pra_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output pra_pkg::pra_out_t   out_data
);
    import pra_pkg::*;

    // stage map: 0 rad parts, 1 rad, 2 x2, 3..20 Horner, 21 sin/cos,
    // 22 products, 23 output
    localparam int LAT      = 24;
    localparam int HORN_END = 2 + 3 * HORNER_STEPS;
    localparam int SIDE_END = HORN_END + 1;

    logic                  en;
    logic [LAT-1:0]        valid_reg;
    pra_item_t             side_reg [SIDE_END+1];
    logic [RAD_WIDTH-1:0]  rad_reg [1:HORN_END];
    logic [29:0]           a_reg;
    logic [16:0]           b_reg;
    logic [RAD_WIDTH-1:0]  x2_reg;
    logic [TRIG_WIDTH-1:0] sin_reg, cos_reg;
    logic signed [PROD_WIDTH-1:0] xc_reg, ys_reg, yc_reg, xs_reg;
    pra_out_t              out_reg;

    logic [RAD_WIDTH-1:0]  sx2 [HORNER_STEPS+1];
    logic [RAD_WIDTH-1:0]  cx2 [HORNER_STEPS+1];
    logic [TRIG_WIDTH-1:0] sk  [HORNER_STEPS+1];
    logic [TRIG_WIDTH-1:0] ck  [HORNER_STEPS+1];

    logic [24:0]           b_full;
    logic [34:0]           b_scaled;
    logic [60:0]           sq;
    logic [60:0]           sin_prod;
    logic [TRIG_WIDTH-1:0] ps, pc;
    logic signed [31:0]    sn, cs, s, c;
    logic signed [SUM_WIDTH-1:0] sum_x, sum_y;
    logic signed [RND_WIDTH-1:0] rx, ry;
    logic                  ovf_x, ovf_y;
    pra_out_t              out_next;

    localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
        {{(SUM_WIDTH-30){1'b0}}, 1'b1, 29'd0};

    assign en        = !valid_reg[LAT-1] || out_ready;
    assign in_pop    = en;
    assign out_valid = valid_reg[LAT-1];
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    assign b_full   = 25'(25'(in_item.oct) * 25'(RAD_R) + 25'(RAD_BIAS));
    assign b_scaled = 35'(b_reg) * 35'(DIV45_RECIP);
    assign sq       = 61'(rad_reg[1]) * 61'(rad_reg[1]) + (61'(1) << 29);

    assign sx2[0] = x2_reg;
    assign cx2[0] = x2_reg;
    assign sk[0]  = ONE_Q30;
    assign ck[0]  = ONE_Q30;

    for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
        pra_step #(.DIV(SIN_DIV[i])) u_sin_step (
            .aclk (aclk),
            .en   (en),
            .x2_i (sx2[i]),
            .k_i  (sk[i]),
            .x2_o (sx2[i+1]),
            .k_o  (sk[i+1])
        );
        pra_step #(.DIV(COS_DIV[i])) u_cos_step (
            .aclk (aclk),
            .en   (en),
            .x2_i (cx2[i]),
            .k_i  (ck[i]),
            .x2_o (cx2[i+1]),
            .k_o  (ck[i+1])
        );
    end

    assign sin_prod = 61'(rad_reg[HORN_END]) * 61'(sk[HORNER_STEPS]);

    // octant fold and quadrant signs
    always_comb begin
        ps = side_reg[SIDE_END].swap ? cos_reg : sin_reg;
        pc = side_reg[SIDE_END].swap ? sin_reg : cos_reg;
        sn = signed'(32'(ps));
        cs = signed'(32'(pc));
        unique case (side_reg[SIDE_END].quad)
            QUAD_0: begin s = sn;  c = cs;  end
            QUAD_1: begin s = cs;  c = -sn; end
            QUAD_2: begin s = -sn; c = -cs; end
            QUAD_3: begin s = -cs; c = sn;  end
            default: begin s = sn; c = cs;  end
        endcase
    end

    always_comb begin
        sum_x = SUM_WIDTH'(xc_reg) + SUM_WIDTH'(ys_reg) + ROUND_HALF;
        sum_y = SUM_WIDTH'(yc_reg) - SUM_WIDTH'(xs_reg) + ROUND_HALF;
        rx    = sum_x[SUM_WIDTH-1:30];
        ry    = sum_y[SUM_WIDTH-1:30];
        ovf_x = (rx[RND_WIDTH-1:COORD_WIDTH-1] != '0) && (rx[RND_WIDTH-1:COORD_WIDTH-1] != '1);
        ovf_y = (ry[RND_WIDTH-1:COORD_WIDTH-1] != '0) && (ry[RND_WIDTH-1:COORD_WIDTH-1] != '1);
        out_next.x_out = ovf_x ? (rx[RND_WIDTH-1] ? COORD_MIN : COORD_MAX)
                               : rx[COORD_WIDTH-1:0];
        out_next.y_out = ovf_y ? (ry[RND_WIDTH-1] ? COORD_MIN : COORD_MAX)
                               : ry[COORD_WIDTH-1:0];
        out_next.saturated = ovf_x || ovf_y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_item;
            for (int i = 1; i <= SIDE_END; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            a_reg      <= 30'(31'(in_item.oct) * 31'(RAD_Q));
            b_reg      <= b_full[24:8];
            rad_reg[1] <= a_reg + RAD_WIDTH'(b_scaled[34:23]);
            for (int i = 2; i <= HORN_END; i++) begin
                rad_reg[i] <= rad_reg[i-1];
            end
            x2_reg  <= sq[59:30];
            sin_reg <= sin_prod[60:30];
            cos_reg <= ck[HORNER_STEPS];
            xc_reg  <= PROD_WIDTH'(side_reg[SIDE_END].x) * PROD_WIDTH'(c);
            ys_reg  <= PROD_WIDTH'(side_reg[SIDE_END].y) * PROD_WIDTH'(s);
            yc_reg  <= PROD_WIDTH'(side_reg[SIDE_END].y) * PROD_WIDTH'(c);
            xs_reg  <= PROD_WIDTH'(side_reg[SIDE_END].x) * PROD_WIDTH'(s);
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/point_rotate_about_origin_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Rotates a Q15.8 point clockwise about the origin by an angle in 1/64 degree.
// s_* channel: one point and angle per transfer (valid/ready).
// m_* channel: rotated point plus a flag set when a coordinate was clipped.
// Throughput: one item per cycle while the back pipeline is not held. From
// input transfer to m_valid an item passes the front stage, the queue and
// the back stages: radian parts, radian, x2, six chained Horner steps of the
// sin/cos evaluation (three registered stages each), sin/cos, products, output.
// The front stage reduces the angle and picks quadrant and octant; a small
// queue (QUEUE_DEPTH entries) sits between it and the arithmetic pipeline.
// When m_valid is high and m_ready low the whole back pipeline holds, the queue
// fills, and then s_ready drops. Results leave from a register, in input order.
// Reset (aresetn low, synchronous) empties the queue and all pipeline stages.
module point_rotate_about_origin_unit #(
    parameter int QUEUE_DEPTH = pra_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pra_pkg::pra_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pra_pkg::pra_out_t m_data
);
    import pra_pkg::*;

    logic      f_valid, f_ready;
    pra_item_t f_item;
    logic      q_valid, q_pop;
    pra_item_t q_item;

    pra_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    pra_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    pra_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_pop    (q_pop),
        .in_item   (q_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
`default_nettype wire

FILE: rtl/pra_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pra_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  pra_pkg::pra_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  pra_pkg::pra_out_t m_data
);
    import pra_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ready_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> s_ready)
        else $error("input not ready after reset");

    // clipping flag implies a coordinate sits at a range limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.x_out == COORD_MAX) || (m_data.x_out == COORD_MIN) ||
            (m_data.y_out == COORD_MAX) || (m_data.y_out == COORD_MIN))
        else $error("saturated flag without a clipped coordinate");

endmodule

bind point_rotate_about_origin_unit pra_checker u_pra_checker (.*);
`default_nettype wire
